@@ sv/ipv4_dotted_quad_parser_defines.svh @@
// Assertion macros shared by the checker of the dotted-quad parser.
// Depends on nothing; included by files that carry assertions.
`ifndef IPV4_DOTTED_QUAD_PARSER_DEFINES_SVH
`define IPV4_DOTTED_QUAD_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge
`define IPQP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dotted-quad parser: implication check failed");

// Next-cycle implication, sampled on the rising clock edge
`define IPQP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dotted-quad parser: next-cycle check failed");

`endif

@@ sv/ipqp_pkg.sv @@
// Types and constants of the dotted-quad parser.
// Used by the front end, the token queue, the back end and the top level.
package ipqp_pkg;

   // Character classes produced by the front end
   typedef enum logic [1:0] {
      TOK_NONE  = 2'd0,
      TOK_DIGIT = 2'd1,
      TOK_DOT   = 2'd2,
      TOK_OTHER = 2'd3
   } kind_type;

   // One classified character on its way to the back end
   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      logic       last;
   } token_type;

   // One result transaction
   typedef struct packed {
      logic        addr_valid;
      logic [31:0] address;
   } rsp_type;

   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [7:0]  DOT_CHAR     = 8'h2E;
   localparam logic [11:0] OCTET_MAX    = 12'd255;
   localparam logic [11:0] DECIMAL_BASE = 12'd10;
   localparam logic [1:0]  MAX_DIGITS   = 2'd3;
   localparam logic [1:0]  LAST_OCTET   = 2'd3;

endpackage

@@ sv/ipqp_front.sv @@
// Front end of the dotted-quad parser: takes request transactions and
// classifies each character into a token. Depends on ipqp_pkg.
module ipqp_front (
   input  logic                 req_push,
   input  logic [7:0]           req_char_byte,
   input  logic                 req_char_present,
   input  logic                 req_last_char,
   input  logic                 queue_full,
   output logic                 req_full,
   output logic                 token_wr,
   output ipqp_pkg::token_type  token
);

   logic is_digit;
   logic [7:0] digit_off;

   // Back-pressure comes straight from the token queue
   assign req_full = queue_full;
   assign token_wr = req_push & ~queue_full;

   // Character classification
   assign digit_off = req_char_byte - ipqp_pkg::CHAR_ZERO;
   assign is_digit  = (req_char_byte >= ipqp_pkg::CHAR_ZERO) &&
                      (req_char_byte <= ipqp_pkg::CHAR_NINE);

   always_comb begin
      token.last  = req_last_char;
      token.digit = digit_off[3:0];
      priority if (!req_char_present) begin
         token.kind = ipqp_pkg::TOK_NONE;
      end else if (is_digit) begin
         token.kind = ipqp_pkg::TOK_DIGIT;
      end else if (req_char_byte == ipqp_pkg::DOT_CHAR) begin
         token.kind = ipqp_pkg::TOK_DOT;
      end else begin
         token.kind = ipqp_pkg::TOK_OTHER;
      end
   end

endmodule

@@ sv/ipqp_fifo.sv @@
// Short token queue between front and back end of the dotted-quad parser.
// Depends on ipqp_pkg for the token type.
module ipqp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  ipqp_pkg::token_type  wr_data,
   output logic                 full,
   input  logic                 rd_en,
   output ipqp_pkg::token_type  rd_data,
   output logic                 empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ipqp_pkg::token_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = slot_ff[rptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (wr_en) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      cnt_in = cnt_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

@@ sv/ipqp_back.sv @@
// Back end of the dotted-quad parser: runs the octet state machine on each
// token and queues finished results. Depends on ipqp_pkg.
module ipqp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tok_empty,
   input  ipqp_pkg::token_type  tok,
   output logic                 tok_rd,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ipqp_pkg::rsp_type    rsp
);

   // Parse state
   logic [1:0]  octet_index_ff,  octet_index_in;
   logic [7:0]  octet_value_ff,  octet_value_in;
   logic [1:0]  digit_count_ff,  digit_count_in;
   logic [23:0] upper_octets_ff, upper_octets_in;
   logic        parse_failed_ff, parse_failed_in;

   // Two-entry result queue
   logic [1:0]        out_cnt_ff, out_cnt_in;
   ipqp_pkg::rsp_type out_slot_ff [2];
   logic              pop_do, push_do, room;
   logic [1:0]        wpos;

   logic [11:0]       next_value;
   logic              ok;
   ipqp_pkg::rsp_type result;

   // Token taken unless it is last and the full result queue gets no pop
   assign pop_do  = rsp_pop & (out_cnt_ff != 2'd0);
   assign room    = (out_cnt_ff != 2'd2) | pop_do;
   assign tok_rd  = ~tok_empty & (~tok.last | room);
   assign push_do = tok_rd & tok.last;

   assign next_value = 12'(octet_value_ff) * ipqp_pkg::DECIMAL_BASE + 12'(tok.digit);

   // Per-character update
   always_comb begin
      octet_index_in  = octet_index_ff;
      octet_value_in  = octet_value_ff;
      digit_count_in  = digit_count_ff;
      upper_octets_in = upper_octets_ff;
      parse_failed_in = parse_failed_ff;
      if (!parse_failed_ff && !tok_empty) begin
         unique case (tok.kind)
            ipqp_pkg::TOK_NONE: begin
            end
            ipqp_pkg::TOK_DIGIT: begin
               if (digit_count_ff == ipqp_pkg::MAX_DIGITS ||
                   next_value > ipqp_pkg::OCTET_MAX) begin
                  parse_failed_in = 1'b1;
               end else begin
                  octet_value_in = next_value[7:0];
                  digit_count_in = digit_count_ff + 2'd1;
               end
            end
            ipqp_pkg::TOK_DOT: begin
               if (digit_count_ff == 2'd0 ||
                   octet_index_ff == ipqp_pkg::LAST_OCTET) begin
                  parse_failed_in = 1'b1;
               end else begin
                  upper_octets_in = {upper_octets_ff[15:0], octet_value_ff};
                  octet_index_in  = octet_index_ff + 2'd1;
                  octet_value_in  = 8'd0;
                  digit_count_in  = 2'd0;
               end
            end
            ipqp_pkg::TOK_OTHER: begin
               parse_failed_in = 1'b1;
            end
         endcase
      end
      ok = ~parse_failed_in && (octet_index_in == ipqp_pkg::LAST_OCTET) &&
           (digit_count_in != 2'd0);
      result.addr_valid = ok;
      result.address    = ok ? {upper_octets_in, octet_value_in} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || push_do) begin
         octet_index_ff  <= 2'd0;
         octet_value_ff  <= 8'd0;
         digit_count_ff  <= 2'd0;
         upper_octets_ff <= 24'd0;
         parse_failed_ff <= 1'b0;
      end else if (tok_rd) begin
         octet_index_ff  <= octet_index_in;
         octet_value_ff  <= octet_value_in;
         digit_count_ff  <= digit_count_in;
         upper_octets_ff <= upper_octets_in;
         parse_failed_ff <= parse_failed_in;
      end
   end

   // Result queue occupancy
   assign wpos       = out_cnt_ff - 2'(pop_do);
   assign out_cnt_in = wpos + 2'(push_do);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   // Result queue storage: shift on pop, write behind the last entry
   always_ff @(posedge clock) begin
      if (push_do && wpos == 2'd0) begin
         out_slot_ff[0] <= result;
      end else if (pop_do) begin
         out_slot_ff[0] <= out_slot_ff[1];
      end
      if (push_do && wpos == 2'd1) begin
         out_slot_ff[1] <= result;
      end
   end

   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp       = out_slot_ff[0];

endmodule

@@ sv/ipv4_dotted_quad_parser.sv @@
// Strict dotted-quad IPv4 address parser, top level.
// Channels: request side (req_push/req_full) takes one character transaction
// a cycle unless req_full: req_char_byte, req_char_present, req_last_char.
// Response queue side (rsp_empty / rsp_pop) gives one transaction per string:
// rsp_addr_valid and rsp_address, first octet in bits 31 to 24, zero when
// the string was not a well-formed dotted quad.
// An item with req_char_present low carries no character; marked last, it
// ends the string (an empty string reports invalid).
// Path: a last character is registered in the token queue, and its result in
// the result queue once the back end takes it.
// Throughput: one character per cycle unless stalled, set by the octet update
// in the back end; the front end classifies into a FIFO_DEPTH token queue.
// Stall: results wait in a two-entry queue; when it fills, the back end holds
// the next last token, the token queue fills and req_full rises.
// Reset (synchronous, active high) empties both queues and clears the parse
// state; req_full is low and rsp_empty high after it.
// Depends on ipqp_pkg, ipqp_front, ipqp_fifo and ipqp_back.
module ipv4_dotted_quad_parser #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_byte,
   input  logic        req_char_present,
   input  logic        req_last_char,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_addr_valid,
   output logic [31:0] rsp_address
);

   ipqp_pkg::token_type wr_token, rd_token;
   ipqp_pkg::rsp_type   rsp;
   logic                token_wr, token_rd, queue_full, queue_empty;

   // Classification
   ipqp_front u_front (
      .req_push         (req_push),
      .req_char_byte    (req_char_byte),
      .req_char_present (req_char_present),
      .req_last_char    (req_last_char),
      .queue_full       (queue_full),
      .req_full         (req_full),
      .token_wr         (token_wr),
      .token            (wr_token)
   );

   // Decoupling queue
   ipqp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (token_wr),
      .wr_data (wr_token),
      .full    (queue_full),
      .rd_en   (token_rd),
      .rd_data (rd_token),
      .empty   (queue_empty)
   );

   // Octet state machine and result queue
   ipqp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_empty (queue_empty),
      .tok       (rd_token),
      .tok_rd    (token_rd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_addr_valid = rsp.addr_valid;
   assign rsp_address    = rsp.address;

endmodule

@@ sv/ipqp_checker.sv @@
// Port-level checks for the dotted-quad parser, bound to its top level.
// Depends on ipv4_dotted_quad_parser_defines.svh and the top level.
`include "ipv4_dotted_quad_parser_defines.svh"

module ipqp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_addr_valid,
   input logic [31:0] rsp_address
);

   // Reset leaves the result queue empty and req_full low
   `IPQP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !req_full)

   // An invalid string never reports a non-zero address
   `IPQP_ASSERT_IMPLY(a_invalid_zero, clock, reset, !rsp_empty && !rsp_addr_valid, rsp_address == 32'd0)

   // A waiting result holds until it is popped
   `IPQP_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_address) && $stable(rsp_addr_valid))

endmodule

bind ipv4_dotted_quad_parser ipqp_checker u_ipqp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_addr_valid (rsp_addr_valid),
   .rsp_address    (rsp_address)
);
